>>> design/ust_pkg.sv
// Shared types and constants for the unsorted set table.
// Used by unsorted_set_table and ust_out_reg; depends on nothing else.
package ust_pkg;

  // Default sizing handed to the top-level parameters.
  localparam int CapacityDef  = 16;
  localparam int ValueBitsDef = 8;

  // Fixed field widths on the stream ports.
  localparam int CmdBits     = 2;
  localparam int ValueInBits = 8;
  localparam int CountBits   = 5;
  localparam int OutDataBits = 8;

  // Command codes carried in the input tuser.
  localparam logic [CmdBits-1:0] CmdInsert = 2'd0;
  localparam logic [CmdBits-1:0] CmdRemove = 2'd1;
  localparam logic [CmdBits-1:0] CmdQuery  = 2'd2;

  // One result word as produced by the table controller.
  typedef struct packed {
    logic                 rejected;
    logic [CountBits-1:0] count;
    logic                 found;
  } ust_res_t;

endpackage

>>> design/ust_out_reg.sv
// Output register stage for the unsorted set table result stream.
// Depends on ust_pkg for the result struct and field widths.
module ust_out_reg import ust_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   res_valid_i,
  output logic                   res_ready_o,
  input  ust_res_t               res_i,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OutDataBits-1:0] m_axis_tdata   // found, count[4:0], rejected, zero pad
);

  logic     vld_q, vld_d;
  ust_res_t res_q;

  assign res_ready_o = !vld_q || m_axis_tready;

  always_comb begin
    vld_d = vld_q;
    if (m_axis_tready) begin
      vld_d = 1'b0;
    end
    if (res_valid_i && res_ready_o) begin
      vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = OutDataBits'({res_q.rejected, res_q.count, res_q.found});

endmodule

>>> design/unsorted_set_table.sv
// Top level of the unsorted set table: controller, entry memory and occupancy count.
// Depends on ust_pkg and instantiates ust_out_reg for the result stream.
//
// Channel   Dir  tdata (low bit up)                  tuser      Meaning
// s_axis    in   value[7:0]                          cmd[1:0]   one command word
// m_axis    out  found, count[4:0], rejected, pad    -          one result word
//
// An absent value goes through an accept step, one memory read per stored entry
// (issued back to back, each compared in the next cycle) and a decide step; an empty
// table skips the reads. A hit in slot j ends the scan early, and a remove that moves
// the last entry into the freed slot adds a move step.
// The next command is taken once the current one has handed its result to the
// output register, even if that register is still waiting on m_axis_tready.
// Reset clears the occupancy and control state at once; no clearing pass runs.
// A stalled output holds the controller in its final step with nothing changed.
module unsorted_set_table import ust_pkg::*; #(
  parameter int CAPACITY   = CapacityDef,
  parameter int VALUE_BITS = ValueBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [ValueInBits-1:0] s_axis_tdata,   // value[7:0]
  input  logic [CmdBits-1:0]     s_axis_tuser,   // cmd[1:0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OutDataBits-1:0] m_axis_tdata    // found, count[4:0], rejected, zero pad
);

  // Address width for the entry memory and width of a count that can hold CAPACITY.
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // Controller states.
  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StDecide = 2'd2;
  localparam logic [1:0] StMove   = 2'd3;

  logic [1:0]            st_q, st_d;
  logic [CW-1:0]         occ_q, occ_d;
  logic [CmdBits-1:0]    cmd_q, cmd_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic                  found_q, found_d;
  logic [AW-1:0]         pos_q, pos_d;
  logic [CW-1:0]         iss_q, iss_d;
  logic                  chk_vld_q, chk_vld_d;
  logic [AW-1:0]         chk_idx_q, chk_idx_d;

  // Entry memory: one write port and one registered read port.
  logic [VALUE_BITS-1:0] mem [CAPACITY];
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [VALUE_BITS-1:0] rdata_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [VALUE_BITS-1:0] mem_wd;

  logic                  in_acc;
  logic [VALUE_BITS-1:0] val_in;
  logic [CW-1:0]         last_idx;
  logic                  hit;
  logic                  last_chk;
  logic                  res_vld;
  logic                  res_rdy;
  logic                  rej;
  ust_res_t              res;

  assign s_axis_tready = (st_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Only the low VALUE_BITS bits of the value take part.
  assign val_in = VALUE_BITS'(s_axis_tdata);

  // Index of the last occupied slot; only used while the table is not empty.
  assign last_idx = occ_q - CW'(1);

  // The compare stage sees the entry read in the previous cycle.
  assign hit      = chk_vld_q && (rdata_q == val_q);
  assign last_chk = chk_vld_q && (CW'(chk_idx_q) == last_idx);

  always_comb begin
    st_d      = st_q;
    occ_d     = occ_q;
    cmd_d     = cmd_q;
    val_d     = val_q;
    found_d   = found_q;
    pos_d     = pos_q;
    iss_d     = iss_q;
    rd_en     = 1'b0;
    rd_addr   = '0;
    mem_we    = 1'b0;
    mem_wa    = '0;
    mem_wd    = val_q;
    res_vld   = 1'b0;
    rej       = 1'b0;

    unique case (st_q)
      StIdle: begin
        if (in_acc) begin
          cmd_d   = s_axis_tuser;
          val_d   = val_in;
          found_d = 1'b0;
          iss_d   = '0;
          st_d    = (occ_q == '0) ? StDecide : StScan;
        end
      end

      StScan: begin
        // Keep issuing reads until every occupied slot has been requested.
        if (iss_q < occ_q) begin
          rd_en   = 1'b1;
          rd_addr = iss_q[AW-1:0];
          iss_d   = iss_q + CW'(1);
        end
        if (hit) begin
          found_d = 1'b1;
          pos_d   = chk_idx_q;
          st_d    = StDecide;
        end else if (last_chk) begin
          st_d = StDecide;
        end
      end

      StDecide: begin
        case (cmd_q)
          CmdInsert: begin
            if (res_rdy) begin
              res_vld = 1'b1;
              st_d    = StIdle;
              if (!found_q) begin
                if (occ_q < CW'(CAPACITY)) begin
                  mem_we = 1'b1;
                  mem_wa = occ_q[AW-1:0];
                  mem_wd = val_q;
                  occ_d  = occ_q + CW'(1);
                end else begin
                  rej = 1'b1;
                end
              end
            end
          end
          CmdRemove: begin
            if (found_q && (CW'(pos_q) != last_idx)) begin
              // Fetch the last entry so it can fill the hole.
              rd_en   = 1'b1;
              rd_addr = last_idx[AW-1:0];
              st_d    = StMove;
            end else if (res_rdy) begin
              res_vld = 1'b1;
              st_d    = StIdle;
              if (found_q) begin
                occ_d = last_idx;
              end
            end
          end
          default: begin
            // Query, and the unused code, only report.
            if (res_rdy) begin
              res_vld = 1'b1;
              st_d    = StIdle;
            end
          end
        endcase
      end

      StMove: begin
        if (res_rdy) begin
          mem_we  = 1'b1;
          mem_wa  = pos_q;
          mem_wd  = rdata_q;
          occ_d   = last_idx;
          res_vld = 1'b1;
          st_d    = StIdle;
        end
      end

      default: begin
        st_d = StIdle;
      end
    endcase

    chk_vld_d = rd_en && (st_q == StScan);
    chk_idx_d = rd_addr;
  end

  always_comb begin
    res.found    = found_q;
    res.count    = CountBits'(occ_d);
    res.rejected = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      occ_q     <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      occ_q     <= occ_d;
      chk_vld_q <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    val_q     <= val_d;
    found_q   <= found_d;
    pos_q     <= pos_d;
    iss_q     <= iss_d;
    chk_idx_q <= chk_idx_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  ust_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_valid_i   (res_vld),
    .res_ready_o   (res_rdy),
    .res_i         (res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // The occupancy never exceeds the table size.
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(CAPACITY))
    else $error("occupancy above capacity");

  // A refused insert only happens on a full table and leaves it full.
  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld && rej) |-> (occ_q == CW'(CAPACITY)) ##1 (occ_q == CW'(CAPACITY)))
    else $error("insert refused while table had room");

  // A value already present is never reported as refused.
  a_found_no_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld |-> !(res.found && res.rejected))
    else $error("present value flagged as refused");

  // Each write into the table lands inside the occupied range or just past it.
  a_write_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (CW'(mem_wa) <= occ_q) && (CW'(mem_wa) < CW'(CAPACITY)))
    else $error("table write outside the valid slots");

endmodule

>>> tb/unsorted_set_table_test.sv
// Self-checking testbench for unsorted_set_table: streams insert, remove and query words
// and checks each result word against a shadow copy of the set. Depends on ust_pkg.
`timescale 1ns / 1ps

module unsorted_set_table_test;
  import ust_pkg::*;

  localparam int Capacity      = CapacityDef;
  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = Capacity + 24;
  localparam int Segments      = 19;
  localparam int SegmentItems  = 100;
  localparam int PoolDepth     = 40;

  typedef struct packed {
    logic [CmdBits-1:0]     cmd;
    logic [ValueInBits-1:0] value;
  } set_cmd_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [ValueInBits-1:0] s_axis_tdata  = '0;   // value[7:0]
  logic [CmdBits-1:0]     s_axis_tuser  = '0;   // cmd[1:0]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata;         // found, count[4:0], rejected, zero pad

  unsorted_set_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  set_cmd_t               pending_cmds[$];
  ust_res_t               predicted_results[$];
  logic [ValueInBits-1:0] shadow_entries[Capacity];
  int                     shadow_count = 0;
  int                     mismatches   = 0;
  int                     src_gap      = 0;
  int                     src_calm     = 0;
  int                     sink_stall   = 0;
  int                     sink_calm    = 0;
  int                     quiet_cycles = 0;

  // Shadow of the table: linear search, append on insert, swap-with-last on remove.
  // Command code 3 falls through to the query behavior.
  function automatic ust_res_t predict_set_op(input set_cmd_t c);
    ust_res_t r;
    logic     hit;
    int       pos;
    hit = 1'b0;
    pos = 0;
    for (int i = 0; i < shadow_count; i++) begin
      if (!hit && shadow_entries[i] == c.value) begin
        hit = 1'b1;
        pos = i;
      end
    end
    r.found    = hit;
    r.rejected = 1'b0;
    case (c.cmd)
      CmdInsert: begin
        if (!hit) begin
          if (shadow_count < Capacity) begin
            shadow_entries[shadow_count] = c.value;
            shadow_count++;
          end else begin
            r.rejected = 1'b1;
          end
        end
      end
      CmdRemove: begin
        if (hit) begin
          shadow_entries[pos] = shadow_entries[shadow_count-1];
          shadow_count--;
        end
      end
      default: ;
    endcase
    r.count = shadow_count[CountBits-1:0];
    return r;
  endfunction

  // Idle length: mostly none or short, a few long, and now and then a calm stretch
  // in which no idling happens at all.
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) begin
      calm = $urandom_range(80, 30);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic set_cmd_t make_cmd(input logic [CmdBits-1:0] cmd,
                                        input logic [ValueInBits-1:0] value);
    set_cmd_t c;
    c.cmd   = cmd;
    c.value = value;
    return c;
  endfunction

  // Source side: each accepted command word is predicted at once, then a gap may follow.
  always @(posedge clk_i) begin
    logic busy;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_results.push_back(predict_set_op(pending_cmds.pop_front()));
        busy    = 1'b0;
        src_gap = idle_len(src_calm);
      end
      if (!busy) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_cmds[0].value;
          s_axis_tuser  <= pending_cmds[0].cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink side: compare each result word with the oldest prediction, then maybe stall.
  always @(posedge clk_i) begin
    ust_res_t exp_res;
    ust_res_t got_res;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_res = ust_res_t'(m_axis_tdata[CountBits+1:0]);
        if (predicted_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word %h with no command outstanding", m_axis_tdata);
        end else begin
          exp_res = predicted_results.pop_front();
          if (got_res.found !== exp_res.found || got_res.count !== exp_res.count ||
              got_res.rejected !== exp_res.rejected ||
              m_axis_tdata[OutDataBits-1:CountBits+2] !== '0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected found=%0d count=%0d rejected=%0d, got %h",
                       exp_res.found, exp_res.count, exp_res.rejected, m_axis_tdata);
          end
        end
        sink_stall = idle_len(sink_calm);
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a run of cycles with no word moving on either side means a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [ValueInBits-1:0] pool[PoolDepth];
    int                     pool_size;
    int                     insert_pct;
    int                     r;
    logic [CmdBits-1:0]     cmd;
    logic [ValueInBits-1:0] value;

    // Directed part: field extremes, present and absent values, every command code,
    // a swap-with-last removal, then a full table with a refused and a repeated insert.
    pending_cmds.push_back(make_cmd(CmdInsert, 8'h00));
    pending_cmds.push_back(make_cmd(CmdInsert, 8'hff));
    pending_cmds.push_back(make_cmd(CmdInsert, 8'hff));
    pending_cmds.push_back(make_cmd(CmdQuery, 8'hff));
    pending_cmds.push_back(make_cmd(2'd3, 8'h00));
    pending_cmds.push_back(make_cmd(CmdRemove, 8'h07));
    pending_cmds.push_back(make_cmd(CmdRemove, 8'h00));
    pending_cmds.push_back(make_cmd(CmdQuery, 8'h00));
    for (int i = 1; i < Capacity; i++)
      pending_cmds.push_back(make_cmd(CmdInsert, ValueInBits'(i * 17)));
    pending_cmds.push_back(make_cmd(CmdInsert, 8'hc8));
    pending_cmds.push_back(make_cmd(CmdInsert, 8'hc9));
    pending_cmds.push_back(make_cmd(CmdInsert, 8'h22));

    // Random part: values come mostly from a small pool per segment so the table keeps
    // filling and emptying; the insert share moves the typical occupancy around.
    for (int s = 0; s < Segments; s++) begin
      pool_size  = $urandom_range(PoolDepth, 6);
      insert_pct = $urandom_range(75, 30);
      for (int k = 0; k < PoolDepth; k++)
        pool[k] = ValueInBits'($urandom);
      for (int n = 0; n < SegmentItems; n++) begin
        r = $urandom_range(99);
        if (r < insert_pct) cmd = CmdInsert;
        else if (r < 88)    cmd = CmdRemove;
        else if (r < 96)    cmd = CmdQuery;
        else                cmd = 2'd3;
        if ($urandom_range(9) == 0) value = ValueInBits'($urandom);
        else                        value = pool[$urandom_range(pool_size - 1)];
        pending_cmds.push_back(make_cmd(cmd, value));
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || predicted_results.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && predicted_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
design/ust_pkg.sv
design/ust_out_reg.sv
design/unsorted_set_table.sv
tb/unsorted_set_table_test.sv
